>>> sv/vmp_pkg.sv
// Shared types, codes and the update-rule table of the Verlet mapping propagator.
// Used by the controller, the datapath and the top level. No dependencies.
package vmp_pkg;

    // Transaction opcodes.
    localparam logic [2:0] OP_WR_OLD = 3'd0;
    localparam logic [2:0] OP_WR_NEW = 3'd1;
    localparam logic [2:0] OP_WR_VAR = 3'd2;
    localparam logic [2:0] OP_STEP   = 3'd3;
    localparam logic [2:0] OP_RD_VAR = 3'd4;

    // Update rules.
    localparam logic [2:0] METH_CMM1 = 3'd0;
    localparam logic [2:0] METH_CMM3 = 3'd1;
    localparam logic [2:0] METH_CMM4 = 3'd2;
    localparam logic [2:0] METH_CMM5 = 3'd3;
    localparam logic [2:0] METH_CMM6 = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_METHOD    = 2'd0;
    localparam logic [1:0] CFG_TIME_STEP = 2'd1;
    localparam logic [1:0] CFG_STATES    = 2'd2;

    // Vector codes.
    localparam logic [1:0] V_X  = 2'd0;
    localparam logic [1:0] V_Y  = 2'd1;
    localparam logic [1:0] V_PX = 2'd2;
    localparam logic [1:0] V_PY = 2'd3;

    // Datapath phases of one multiply-accumulate.
    localparam logic [2:0] PH_NONE = 3'd0;
    localparam logic [2:0] PH_A    = 3'd1;
    localparam logic [2:0] PH_B    = 3'd2;
    localparam logic [2:0] PH_D    = 3'd3;
    localparam logic [2:0] PH_MUL  = 3'd4;
    localparam logic [2:0] PH_WB   = 3'd5;

    // One accumulation pass: dst[n] += (e/8*dt) * H[n][j] * (a[j] +/- b[j]).
    typedef struct packed {
        logic              diag;     // j = n, single term; otherwise j sweeps
        logic [1:0]        dst;
        logic [1:0]        vec_a;
        logic [1:0]        vec_b;
        logic              use_b;
        logic              sub_b;
        logic signed [4:0] eighths;
    } t_uop;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic [2:0] phase;
        logic       host_wr;
        logic       host_rd;
        logic       load_out;
        logic       out_rd;
        logic       hsel_new;
        t_uop       uop;
    } t_dp_cmd;

    function automatic t_uop mk_uop(input logic diag, input logic [1:0] dst,
                                    input logic [1:0] va, input logic [1:0] vb,
                                    input logic use_b, input logic sub_b,
                                    input logic signed [4:0] e);
        t_uop u;
        u.diag    = diag;
        u.dst     = dst;
        u.vec_a   = va;
        u.vec_b   = vb;
        u.use_b   = use_b;
        u.sub_b   = sub_b;
        u.eighths = e;
        return u;
    endfunction

    // Pass table: rule, stage (0 half old, 1 full new, 2 half new) and pass number.
    function automatic t_uop uop_desc(input logic [2:0] method, input logic [1:0] stage,
                                      input logic [2:0] pass);
        t_uop              u;
        logic              full;
        logic [2:0]        p;
        logic signed [4:0] sc;
        u    = '0;
        full = (stage == 2'd1);
        p    = (pass >= 3'd4) ? pass - 3'd4 : pass;
        sc   = (method == METH_CMM6) ? 5'sd2 : 5'sd1;
        case (method)
            METH_CMM1: begin
                if (!full) begin
                    u = (pass == 3'd0) ? mk_uop(1'b0, V_X, V_Y, V_Y, 1'b0, 1'b0, -5'sd4)
                                       : mk_uop(1'b0, V_PX, V_PY, V_PY, 1'b0, 1'b0, -5'sd4);
                end else begin
                    u = (pass == 3'd0) ? mk_uop(1'b0, V_Y, V_X, V_X, 1'b0, 1'b0, 5'sd8)
                                       : mk_uop(1'b0, V_PY, V_PX, V_PX, 1'b0, 1'b0, 5'sd8);
                end
            end
            METH_CMM3: begin
                if (!full) begin
                    case (p)
                        3'd0:    u = mk_uop(1'b1, V_PX, V_X, V_PY, 1'b1, 1'b1, -5'sd1);
                        3'd1:    u = mk_uop(1'b0, V_PX, V_PY, V_PY, 1'b0, 1'b0, -5'sd2);
                        3'd2:    u = mk_uop(1'b1, V_X, V_PX, V_Y, 1'b1, 1'b0, 5'sd2);
                        default: u = mk_uop(1'b0, V_X, V_Y, V_Y, 1'b0, 1'b0, -5'sd4);
                    endcase
                end else begin
                    case (p)
                        3'd0:    u = mk_uop(1'b1, V_PY, V_PX, V_Y, 1'b1, 1'b0, -5'sd2);
                        3'd1:    u = mk_uop(1'b0, V_PY, V_PX, V_PX, 1'b0, 1'b0, 5'sd4);
                        3'd2:    u = mk_uop(1'b1, V_Y, V_PY, V_X, 1'b1, 1'b1, 5'sd4);
                        default: u = mk_uop(1'b0, V_Y, V_X, V_X, 1'b0, 1'b0, 5'sd8);
                    endcase
                end
            end
            METH_CMM4, METH_CMM6: begin
                if (!full) begin
                    case (p)
                        3'd0:    u = mk_uop(1'b1, V_PX, V_PY, V_X, 1'b1, 1'b1, -sc);
                        3'd1:    u = mk_uop(1'b0, V_PX, V_X, V_X, 1'b0, 1'b0, -5'sd2);
                        3'd2:    u = mk_uop(1'b1, V_PY, V_PX, V_Y, 1'b1, 1'b0, 5'(2 * sc));
                        default: u = mk_uop(1'b0, V_PY, V_Y, V_Y, 1'b0, 1'b0, -5'sd4);
                    endcase
                end else begin
                    case (p)
                        3'd0:    u = mk_uop(1'b1, V_X, V_PX, V_Y, 1'b1, 1'b0, 5'(-2 * sc));
                        3'd1:    u = mk_uop(1'b0, V_X, V_PX, V_PX, 1'b0, 1'b0, 5'sd4);
                        3'd2:    u = mk_uop(1'b1, V_Y, V_X, V_PY, 1'b1, 1'b1, 5'(4 * sc));
                        default: u = mk_uop(1'b0, V_Y, V_PY, V_PY, 1'b0, 1'b0, 5'sd8);
                    endcase
                end
            end
            METH_CMM5: begin
                if (!full) begin
                    u = (pass == 3'd1) ? mk_uop(1'b0, V_X, V_PX, V_Y, 1'b1, 1'b1, 5'sd2)
                                       : mk_uop(1'b0, V_PX, V_PY, V_X, 1'b1, 1'b0, -5'sd1);
                end else begin
                    u = (pass == 3'd1) ? mk_uop(1'b0, V_Y, V_X, V_PY, 1'b1, 1'b0, 5'sd4)
                                       : mk_uop(1'b0, V_PY, V_PX, V_Y, 1'b1, 1'b1, 5'sd2);
                end
            end
            default: u = '0;
        endcase
        return u;
    endfunction

endpackage

>>> sv/vmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vmp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/vmp_datapath.sv
// Datapath: matrix and vector RAMs, the saturating Q8.24 multiply-accumulate
// pipeline, the sticky saturation flag and the result register. Uses vmp_pkg, vmp_ram.
module vmp_datapath #(
    parameter int MAX_STATES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  vmp_pkg::t_dp_cmd                i_cmd,
    input  logic [$clog2(MAX_STATES+1)-1:0] i_n,
    input  logic [$clog2(MAX_STATES+1)-1:0] i_m,
    input  logic [2:0]                      i_opcode,
    input  logic [2:0]                      i_row_index,
    input  logic [2:0]                      i_column_index,
    input  logic [1:0]                      i_variable_select,
    input  logic signed [31:0]              i_write_value,
    input  logic [30:0]                     i_time_step,
    output logic signed [31:0]              o_read_value,
    output logic                            o_saturated
);
    import vmp_pkg::*;

    localparam int CW   = $clog2(MAX_STATES + 1);
    localparam int VAW  = $clog2(4 * MAX_STATES);
    localparam int MAW  = $clog2(2 * MAX_STATES * MAX_STATES);

    // Saturate to 32 bits; bit 32 flags an overflow.
    function automatic logic [32:0] sat_w(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    // Q8.24 product with round-half-up, saturated.
    function automatic logic [32:0] smul(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
        logic signed [63:0] p;
        p = (64'(a) * 64'(b)) + 64'sd8388608;
        return sat_w(p >>> 24);
    endfunction

    logic                    row_ok, col_ok;
    logic                    v_re, v_we, m_re, m_we;
    logic [VAW-1:0]          v_raddr, v_waddr;
    logic [MAW-1:0]          m_raddr, m_waddr;
    logic [31:0]             v_wdata, v_rdata, m_rdata;
    logic [1:0]              v_sel;
    logic [CW-1:0]           v_idx, j_idx;
    logic signed [36:0]      dt_prod;
    logic [32:0]             coef_w, kh_w, opd_w, t_w, wb_w;
    logic                    sat_hit;

    logic signed [31:0]      r_coef, r_kh, r_a, r_opd, r_dst, r_t;
    logic                    r_sat, r_rd_ok, r_out_sat;
    logic signed [31:0]      r_out_val;

    assign row_ok = (int'(i_row_index) < MAX_STATES);
    assign col_ok = (int'(i_column_index) < MAX_STATES);
    assign j_idx  = i_cmd.uop.diag ? i_n : i_m;

    // Vector RAM read address selection.
    always_comb begin
        v_re  = 1'b0;
        v_sel = i_cmd.uop.dst;
        v_idx = i_n;
        case (i_cmd.phase)
            PH_A: begin
                v_re  = 1'b1;
                v_sel = i_cmd.uop.vec_a;
                v_idx = j_idx;
            end
            PH_B: begin
                v_re  = 1'b1;
                v_sel = i_cmd.uop.vec_b;
                v_idx = j_idx;
            end
            PH_D: begin
                v_re  = 1'b1;
            end
            default: begin
            end
        endcase
        if (i_cmd.host_rd) begin
            v_re    = 1'b1;
            v_raddr = VAW'(int'(i_variable_select) * MAX_STATES + int'(i_row_index));
        end else begin
            v_raddr = VAW'(int'(v_sel) * MAX_STATES + int'(v_idx));
        end
    end

    // Vector RAM write: host loads or the write-back of an accumulation.
    always_comb begin
        if (i_cmd.host_wr) begin
            v_we    = (i_opcode == OP_WR_VAR) && row_ok;
            v_waddr = VAW'(int'(i_variable_select) * MAX_STATES + int'(i_row_index));
            v_wdata = i_write_value;
        end else begin
            v_we    = (i_cmd.phase == PH_WB);
            v_waddr = VAW'(int'(i_cmd.uop.dst) * MAX_STATES + int'(i_n));
            v_wdata = wb_w[31:0];
        end
    end

    // Matrix RAM: old matrix in the lower half, new matrix in the upper half.
    always_comb begin
        m_we    = i_cmd.host_wr && ((i_opcode == OP_WR_OLD) || (i_opcode == OP_WR_NEW))
                  && row_ok && col_ok;
        m_waddr = MAW'(((i_opcode == OP_WR_NEW) ? MAX_STATES * MAX_STATES : 0)
                       + int'(i_row_index) * MAX_STATES + int'(i_column_index));
        m_re    = (i_cmd.phase == PH_A);
        m_raddr = MAW'((i_cmd.hsel_new ? MAX_STATES * MAX_STATES : 0)
                       + int'(i_n) * MAX_STATES + int'(j_idx));
    end

    vmp_ram #(.WIDTH(32), .DEPTH(4 * MAX_STATES)) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_re    (v_re),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    vmp_ram #(.WIDTH(32), .DEPTH(2 * MAX_STATES * MAX_STATES)) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (i_write_value),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    // Arithmetic of each phase.
    always_comb begin
        dt_prod = $signed({6'b0, i_time_step}) * 37'(i_cmd.uop.eighths);
        coef_w  = sat_w(64'((dt_prod + 37'sd4) >>> 3));
        kh_w    = smul(r_coef, $signed(m_rdata));
        if (i_cmd.uop.sub_b) begin
            opd_w = sat_w(64'(r_a) - 64'($signed(v_rdata)));
        end else begin
            opd_w = sat_w(64'(r_a) + 64'($signed(v_rdata)));
        end
        t_w     = smul(r_kh, r_opd);
        wb_w    = sat_w(64'(r_dst) + 64'(r_t));
        case (i_cmd.phase)
            PH_A:    sat_hit = coef_w[32];
            PH_B:    sat_hit = kh_w[32];
            PH_D:    sat_hit = opd_w[32] && i_cmd.uop.use_b;
            PH_MUL:  sat_hit = t_w[32];
            PH_WB:   sat_hit = wb_w[32];
            default: sat_hit = 1'b0;
        endcase
    end

    // Pipeline registers of the multiply-accumulate.
    always_ff @(posedge i_clk) begin
        case (i_cmd.phase)
            PH_A: r_coef <= $signed(coef_w[31:0]);
            PH_B: begin
                r_a  <= $signed(v_rdata);
                r_kh <= $signed(kh_w[31:0]);
            end
            PH_D: r_opd <= i_cmd.uop.use_b ? $signed(opd_w[31:0]) : r_a;
            PH_MUL: begin
                r_dst <= $signed(v_rdata);
                r_t   <= $signed(t_w[31:0]);
            end
            default: begin
            end
        endcase
        if (i_cmd.host_rd) begin
            r_rd_ok <= row_ok;
        end
        if (i_cmd.load_out) begin
            r_out_val <= (i_cmd.out_rd && r_rd_ok) ? $signed(v_rdata) : 32'sd0;
        end
    end

    // Sticky saturation flag and the flag copy in the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat     <= 1'b0;
            r_out_sat <= 1'b0;
        end else begin
            if (sat_hit) begin
                r_sat <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_sat <= r_sat;
            end
        end
    end

    assign o_read_value = r_out_val;
    assign o_saturated  = r_out_sat;
endmodule

>>> sv/vmp_ctrl.sv
// Controller: handshakes, the step sequencer over stages, passes and indexes,
// and the phase sequence of each multiply-accumulate. Uses vmp_pkg.
module vmp_ctrl #(
    parameter int MAX_STATES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [2:0]                      i_opcode,
    output logic                            o_valid,
    input  logic                            i_ready,
    input  logic [2:0]                      i_method,
    input  logic [3:0]                      i_state_count,
    output vmp_pkg::t_dp_cmd                o_cmd,
    output logic [$clog2(MAX_STATES+1)-1:0] o_n,
    output logic [$clog2(MAX_STATES+1)-1:0] o_m
);
    import vmp_pkg::*;

    localparam int CW = $clog2(MAX_STATES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDV  = 3'd1;
    localparam logic [2:0] S_A    = 3'd2;
    localparam logic [2:0] S_B    = 3'd3;
    localparam logic [2:0] S_D    = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_WB   = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_st, n_st;
    logic [2:0]    r_pass, n_pass;
    logic [CW-1:0] r_n, n_n, r_m, n_m;
    logic          r_ovalid, n_ovalid;

    logic [CW-1:0] cnt, cnt_m1;
    logic [2:0]    last_pass;
    logic          accept, is5, last_m, last_n, last_p, last_st, can_step;
    t_uop          uop;

    assign cnt    = (int'(i_state_count) > MAX_STATES) ? CW'(MAX_STATES) : CW'(i_state_count);
    assign cnt_m1 = cnt - CW'(1);
    assign is5    = (i_method == METH_CMM5);
    assign uop    = uop_desc(i_method, r_st, r_pass);
    assign can_step = (i_method <= METH_CMM6) && (cnt != '0);

    always_comb begin
        case (i_method)
            METH_CMM1: last_pass = 3'd1;
            METH_CMM5: last_pass = 3'd2;
            default:   last_pass = 3'd5;
        endcase
    end

    assign last_m  = uop.diag || (r_m == cnt_m1);
    assign last_n  = (r_n == cnt_m1);
    assign last_p  = (r_pass == last_pass);
    assign last_st = (r_st == 2'd2);

    assign o_ready = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign accept  = i_valid && o_ready;

    // Next state, loop counters and datapath command.
    always_comb begin
        n_state  = r_state;
        n_st     = r_st;
        n_pass   = r_pass;
        n_n      = r_n;
        n_m      = r_m;
        n_ovalid = r_ovalid && !i_ready;
        o_cmd          = '0;
        o_cmd.uop      = uop;
        o_cmd.hsel_new = (r_st != 2'd0);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        OP_WR_OLD, OP_WR_NEW, OP_WR_VAR: begin
                            o_cmd.host_wr  = 1'b1;
                            o_cmd.load_out = 1'b1;
                            n_ovalid       = 1'b1;
                        end
                        OP_RD_VAR: begin
                            o_cmd.host_rd = 1'b1;
                            n_state       = S_RDV;
                        end
                        OP_STEP: begin
                            if (can_step) begin
                                n_st    = '0;
                                n_pass  = '0;
                                n_n     = '0;
                                n_m     = '0;
                                n_state = S_A;
                            end else begin
                                o_cmd.load_out = 1'b1;
                                n_ovalid       = 1'b1;
                            end
                        end
                        default: begin
                            o_cmd.load_out = 1'b1;
                            n_ovalid       = 1'b1;
                        end
                    endcase
                end
            end
            S_RDV: begin
                o_cmd.load_out = 1'b1;
                o_cmd.out_rd   = 1'b1;
                n_ovalid       = 1'b1;
                n_state        = S_IDLE;
            end
            S_A: begin
                o_cmd.phase = PH_A;
                n_state     = S_B;
            end
            S_B: begin
                o_cmd.phase = PH_B;
                n_state     = S_D;
            end
            S_D: begin
                o_cmd.phase = PH_D;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.phase = PH_MUL;
                n_state     = S_WB;
            end
            S_WB: begin
                // Write back, then step the loop nest: term, then index and pass
                // (the sweep rule runs passes outside the row index).
                o_cmd.phase = PH_WB;
                n_state     = S_A;
                if (!last_m) begin
                    n_m = r_m + CW'(1);
                end else begin
                    n_m = '0;
                    if (is5) begin
                        if (!last_n) begin
                            n_n = r_n + CW'(1);
                        end else begin
                            n_n = '0;
                            if (!last_p) begin
                                n_pass = r_pass + 3'd1;
                            end else begin
                                n_pass = '0;
                                if (!last_st) n_st = r_st + 2'd1;
                                else n_state = S_DONE;
                            end
                        end
                    end else begin
                        if (!last_p) begin
                            n_pass = r_pass + 3'd1;
                        end else begin
                            n_pass = '0;
                            if (!last_n) begin
                                n_n = r_n + CW'(1);
                            end else begin
                                n_n = '0;
                                if (!last_st) n_st = r_st + 2'd1;
                                else n_state = S_DONE;
                            end
                        end
                    end
                end
            end
            S_DONE: begin
                o_cmd.load_out = 1'b1;
                n_ovalid       = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_st     <= '0;
            r_pass   <= '0;
            r_n      <= '0;
            r_m      <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_st     <= n_st;
            r_pass   <= n_pass;
            r_n      <= n_n;
            r_m      <= n_m;
        end
    end

    assign o_valid = r_ovalid;
    assign o_n     = r_n;
    assign o_m     = r_m;
endmodule

>>> sv/verlet_mapping_propagator_core.sv
// Top level of the Verlet mapping propagator: configuration registers and the
// controller and datapath instances. Uses vmp_pkg, vmp_ctrl, vmp_datapath.
//
// Usage: each input transaction (i_valid/o_ready) carries one command: load an
// element of the old or new Hamiltonian, load a vector element, run a step, or
// read a vector element. Every command returns exactly one result transaction
// (o_valid/i_ready) with the read value (zero for non-reads) and the sticky
// saturation flag.
// Latency: loads return in the cycle after acceptance; reads go through S_RDV.
// A step runs every multiply-accumulate through phases A, B, D, MUL and WB on
// two multipliers and single-read vector and matrix RAMs. With n states a step
// is 3*2*n*n terms for CMM1, 3*3*n*n for CMM5 and 3*3*n*(n+1) for the others.
// Throughput: one command at a time, accepted while the result register is
// free or being emptied: a load every cycle, none while a read sits in S_RDV.
// Stalls: a result waits in the output register while i_ready is low; the next
// command is accepted only once that register can take its result.
// Reset (synchronous, active low) clears the flag, the handshake state and the
// configuration to CMM1, dt = 167772 (about 0.01) and two states. Matrix and
// vector contents are undefined until written.
module verlet_mapping_propagator_core #(
    parameter int MAX_STATES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_opcode,
    input  logic [2:0]         i_row_index,
    input  logic [2:0]         i_column_index,
    input  logic [1:0]         i_variable_select,
    input  logic signed [31:0] i_write_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_read_value,
    output logic               o_saturated,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [30:0]        i_cfg_wdata
);
    import vmp_pkg::*;

    localparam int CW = $clog2(MAX_STATES + 1);

    logic [2:0]  r_method;
    logic [30:0] r_time_step;
    logic [3:0]  r_state_count;
    t_dp_cmd     cmd;
    logic [CW-1:0] idx_n, idx_m;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method      <= METH_CMM1;
            r_time_step   <= 31'd167772;
            r_state_count <= 4'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_METHOD:    r_method      <= i_cfg_wdata[2:0];
                CFG_TIME_STEP: r_time_step   <= i_cfg_wdata;
                CFG_STATES:    r_state_count <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    vmp_ctrl #(.MAX_STATES(MAX_STATES)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .i_method      (r_method),
        .i_state_count (r_state_count),
        .o_cmd         (cmd),
        .o_n           (idx_n),
        .o_m           (idx_m)
    );

    vmp_datapath #(.MAX_STATES(MAX_STATES)) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_n               (idx_n),
        .i_m               (idx_m),
        .i_opcode          (i_opcode),
        .i_row_index       (i_row_index),
        .i_column_index    (i_column_index),
        .i_variable_select (i_variable_select),
        .i_write_value     (i_write_value),
        .i_time_step       (r_time_step),
        .o_read_value      (o_read_value),
        .o_saturated       (o_saturated)
    );
endmodule
